// ----- rtl/shrd_pkg.sv -----
// Shared types, constants and helpers for the sync-hunt record deframer.
package shrd_pkg;

	localparam int MARKER_LEN       = 9;
	localparam int HEADER_BYTES_DEF = 20;
	localparam int OFFSET_BIAS      = 8;
	localparam int SEG_EXTRA        = 7;
	localparam int RESQ_DEPTH       = 4;
	localparam int RESQ_PW          = $clog2(RESQ_DEPTH);

	localparam logic [15:0] MAX_RECORD = 16'd32772;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_SEGMENT,
		PH_TRAIL
	} phase_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [13:0] segment_count;
		logic        truncated;
	} result_t;

	// up to two results per input beat; r0 goes out first
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic [7:0] marker_byte(input logic [3:0] idx);
		logic [7:0] val;
		unique case (idx)
			4'd0:    val = 8'h4E;
			4'd1:    val = 8'h4A;
			4'd2:    val = 8'h50;
			4'd3:    val = 8'h4C;
			4'd4:    val = 8'h32;
			4'd5:    val = 8'h49;
			4'd6:    val = 8'h30;
			4'd7:    val = 8'h30;
			4'd8:    val = 8'h43;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	// shift one length byte in, saturating at 16 bits
	function automatic logic [15:0] sat_shift(input logic [15:0] len, input logic [7:0] b);
		logic [15:0] val;
		if (len[15:8] != 8'h00) begin
			val = 16'hFFFF;
		end else begin
			val = {len[7:0], b};
		end
		return val;
	endfunction

endpackage

// ----- rtl/shrd_core.sv -----
// Per-byte deframing logic: marker hunt, header, record and segment tracking.
module shrd_core import shrd_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] data_byte,
	output push_t      push
);

	localparam int HIW = $clog2(HEADER_BYTES + 1);

	phase_t          phase_q, phase_d;
	logic [HIW-1:0]  hidx_q, hidx_d;
	logic [15:0]     rlen_q, rlen_d;
	logic [15:0]     ridx_q, ridx_d;
	logic [15:0]     soff_q, soff_d;
	logic [13:0]     slen_q, slen_d;
	logic [7:0]      held_q, held_d;
	logic            hv_q, hv_d;

	logic [3:0]      hi;
	logic [15:0]     rl_hdr;
	logic [15:0]     rclamp;
	logic [16:0]     start;
	logic [15:0]     k;
	logic [14:0]     total;
	logic            done;
	logic [1:0]      num;
	result_t         r0, r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hidx_q  <= '0;
			rlen_q  <= '0;
			ridx_q  <= '0;
			soff_q  <= '0;
			slen_q  <= '0;
			held_q  <= '0;
			hv_q    <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			rlen_q  <= rlen_d;
			ridx_q  <= ridx_d;
			soff_q  <= soff_d;
			slen_q  <= slen_d;
			held_q  <= held_d;
			hv_q    <= hv_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hidx_d  = hidx_q;
		rlen_d  = rlen_q;
		ridx_d  = ridx_q;
		soff_d  = soff_q;
		slen_d  = slen_q;
		held_d  = held_q;
		hv_d    = hv_q;
		num     = 2'd0;
		r0      = '0;
		r1      = '0;
		rl_hdr  = '0;
		rclamp  = '0;
		start   = '0;
		k       = '0;
		total   = '0;
		done    = 1'b0;
		hi      = (hidx_q < HIW'(MARKER_LEN)) ? hidx_q[3:0] : 4'd0;

		unique case (phase_q) inside
			PH_HUNT: begin
				if (data_byte == marker_byte(hi)) begin
					rl_hdr = (hi == 4'd0) ? 16'd0 : rlen_q;
					if (HIW'(hi) >= HIW'(HEADER_BYTES - 4)) begin
						rl_hdr = sat_shift(rl_hdr, data_byte);
					end
					rlen_d = rl_hdr;
					hidx_d = HIW'(hi) + HIW'(1);
					if (hidx_d >= HIW'(MARKER_LEN)) begin
						phase_d = PH_HEADER;
					end
				end else if (data_byte == marker_byte(4'd0)) begin
					// mismatch that is itself a marker start
					hidx_d = HIW'(1);
					rlen_d = '0;
				end else begin
					hidx_d = '0;
				end
			end
			PH_HEADER: begin
				rl_hdr = rlen_q;
				if (hidx_q >= HIW'(HEADER_BYTES - 4)) begin
					rl_hdr = sat_shift(rlen_q, data_byte);
				end
				rlen_d = rl_hdr;
				hidx_d = hidx_q + HIW'(1);
				if (hidx_q == HIW'(HEADER_BYTES - 1)) begin
					rclamp = (rl_hdr > MAX_RECORD) ? MAX_RECORD : rl_hdr;
					rlen_d = rclamp;
					hidx_d = '0;
					ridx_d = '0;
					soff_d = '0;
					slen_d = '0;
					held_d = '0;
					hv_d   = 1'b0;
					if (rclamp == 16'd0) begin
						// empty record: flag it and resume hunting
						phase_d      = PH_HUNT;
						num          = 2'd1;
						r0.last      = 1'b1;
						r0.truncated = 1'b1;
					end else begin
						phase_d = PH_SEGMENT;
					end
				end
			end
			PH_SEGMENT, PH_TRAIL: begin
				if (phase_q == PH_SEGMENT) begin
					if (ridx_q == 16'd2) begin
						soff_d = {data_byte, 8'h00};
					end else if (ridx_q == 16'd3) begin
						soff_d = {soff_q[15:8], data_byte};
					end
					start = {1'b0, soff_d} + 17'(OFFSET_BIAS);
					if ({1'b0, ridx_q} >= start) begin
						k = ridx_q - start[15:0];
						if (k == 16'd4) begin
							slen_d = {data_byte[5:0], 8'h00};
						end else if (k == 16'd5) begin
							slen_d = {slen_q[13:8], data_byte};
						end
						total = {1'b0, slen_d} + 15'(SEG_EXTRA);
						done  = (k >= 16'd5) && (({1'b0, k} + 17'd1) == {2'b00, total});
						if (!k[0]) begin
							held_d = data_byte;
							hv_d   = 1'b1;
							if (done) begin
								// odd-length segment: final byte goes alone
								r0 = '{out_byte: data_byte, last: 1'b1,
									segment_count: slen_d, truncated: 1'b0};
								num     = 2'd1;
								hv_d    = 1'b0;
								phase_d = PH_TRAIL;
							end
						end else begin
							r0.out_byte = data_byte;
							r1.out_byte = hv_q ? held_q : 8'h00;
							num         = 2'd2;
							hv_d        = 1'b0;
							if (done) begin
								r1.last          = 1'b1;
								r1.segment_count = slen_d;
								phase_d          = PH_TRAIL;
							end
						end
					end
				end
				ridx_d = ridx_q + 16'd1;
				if (ridx_d >= rlen_q) begin
					if (phase_d == PH_SEGMENT) begin
						// record ran out with the segment still open
						if (num == 2'd2) begin
							r1.last          = 1'b1;
							r1.segment_count = slen_d;
							r1.truncated     = 1'b1;
						end else begin
							num              = 2'd1;
							r0.out_byte      = hv_d ? held_d : 8'h00;
							r0.last          = 1'b1;
							r0.segment_count = slen_d;
							r0.truncated     = 1'b1;
						end
					end
					hv_d    = 1'b0;
					phase_d = PH_HUNT;
					hidx_d  = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase

		push.num = go ? num : 2'd0;
		push.r0  = r0;
		push.r1  = r1;
	end

	a_hunt_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> hidx_q < HIW'(MARKER_LEN))
		else $error("marker index out of range while hunting");

	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> hidx_q >= HIW'(MARKER_LEN))
		else $error("header phase entered before full marker");

	a_rec_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEGMENT || phase_q == PH_TRAIL) |-> ridx_q < rlen_q)
		else $error("record index ran past record length");

endmodule

// ----- rtl/shrd_resq.sv -----
// Small queue: up to two results in per cycle; one beat out per cycle unless stalled.
module shrd_resq import shrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t head
);

	result_t            ent_q [RESQ_DEPTH];
	logic [RESQ_PW-1:0] wr_q, rd_q;
	logic [RESQ_PW:0]   cnt_q;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q <= (RESQ_PW + 1)'(RESQ_DEPTH - 2));
	assign head      = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			ent_q[wr_q + RESQ_PW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RESQ_PW'(push.num);
			rd_q  <= rd_q + RESQ_PW'(pop);
			cnt_q <= cnt_q + (RESQ_PW + 1)'(push.num) - (RESQ_PW + 1)'(pop);
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (RESQ_PW + 1)'(RESQ_DEPTH))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> room)
		else $error("results pushed without two free slots");

endmodule

// ----- rtl/sync_hunt_record_deframer.sv -----
// Top level of the sync-hunt record deframer: input register, deframing core, result queue.
// Data path: a byte accepted into the input register is decoded from it, and its results
//   enter the queue at the first later edge where the queue has two free entries; the
//   first result is offered on the outputs after that edge.
// Throughput: one byte per cycle; results leave at one beat per cycle, unless the receiver
//   stalls, through a 4-entry queue. A held byte waits while the queue has fewer than two
//   free entries, and input stalls only while that byte waits.
// Reset: arst_n clears phase, counters, hold flag and queue pointers at once; queue
//   entries and the input byte register are not reset.
module sync_hunt_record_deframer import shrd_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [13:0] segment_count,
	output logic        truncated
);

	// input register stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       room;
	logic       go;
	logic       in_acc;
	push_t      push;
	result_t    head;

	// the held beat is decoded once the queue can take a worst-case pair
	assign go       = vld_s1 && room;
	assign in_stall = vld_s1 && !room;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	// payload only; no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= data_byte;
		end
	end

	shrd_core #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.data_byte (byte_s1),
		.push      (push)
	);

	shrd_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte      = head.out_byte;
	assign last          = head.last;
	assign segment_count = head.segment_count;
	assign truncated     = head.truncated;

	// an offered beat is only withdrawn by being taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output beat dropped while stalled");

endmodule

// ----- bench/deframe_checker.sv -----
// Checker for the sync-hunt record deframer: byte-level predictor and result scoreboard.
`timescale 1ns / 100ps

module deframe_checker import shrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        last,
	input  logic [13:0] segment_count,
	input  logic        truncated,
	output int          fail_count,
	output int          pending
);

	localparam int HDR_LEN = HEADER_BYTES_DEF;
	localparam logic [0:8][7:0] SYNC_MARK = {
		8'h4E, 8'h4A, 8'h50, 8'h4C, 8'h32, 8'h49, 8'h30, 8'h30, 8'h43
	};

	// predictor state
	phase_t      ph;
	logic [4:0]  hdr_idx;
	logic [15:0] rec_len;
	logic [15:0] rec_idx;
	logic [15:0] seg_off;
	logic [13:0] seg_len;
	logic [7:0]  held;
	logic        held_v;

	result_t expected_beats[$];

	function automatic result_t make_beat(input logic [7:0] by, input logic la,
			input logic [13:0] cnt, input logic tr);
		return {by, la, cnt, tr};
	endfunction

	// header byte; returns number of beats (zero-length record gives one)
	task automatic take_header(input logic [7:0] b, output int n, output result_t r);
		logic [23:0] v;
		n = 0;
		r = '0;
		if (hdr_idx >= HDR_LEN - 4) begin
			v = {rec_len, b};
			rec_len = (v > 24'h00FFFF) ? 16'hFFFF : v[15:0];
		end
		hdr_idx = hdr_idx + 5'd1;
		if (hdr_idx >= HDR_LEN) begin
			hdr_idx = '0;
			if (rec_len > MAX_RECORD)
				rec_len = MAX_RECORD;
			rec_idx = '0;
			seg_off = '0;
			seg_len = '0;
			held    = '0;
			held_v  = 1'b0;
			if (rec_len == 16'd0) begin
				ph = PH_HUNT;
				r  = make_beat(8'h00, 1'b1, 14'd0, 1'b1);
				n  = 1;
			end else begin
				ph = PH_SEGMENT;
			end
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		result_t     r[2];
		int          n;
		int unsigned hi, pos, start, k, total;
		bit          known;
		n = 0;
		r[0] = '0;
		r[1] = '0;
		if (ph == PH_HUNT) begin
			hi = (hdr_idx < MARKER_LEN) ? hdr_idx : 0;
			if (b == SYNC_MARK[hi]) begin
				if (hi == 0)
					rec_len = '0;
				hdr_idx = hi[4:0];
				take_header(b, n, r[0]);
				if (ph == PH_HUNT && hdr_idx >= MARKER_LEN)
					ph = PH_HEADER;
			end else if (b == SYNC_MARK[0]) begin
				// mismatch that is itself a marker start
				hdr_idx = 5'd1;
				rec_len = '0;
			end else begin
				hdr_idx = '0;
			end
		end else if (ph == PH_HEADER) begin
			take_header(b, n, r[0]);
		end else begin
			pos = rec_idx;
			if (ph == PH_SEGMENT) begin
				if (pos == 2)
					seg_off = {b, 8'h00};
				else if (pos == 3)
					seg_off[7:0] = b;
				start = seg_off + 8;
				if (pos >= 8 && pos >= start) begin
					k     = pos - start;
					known = (k >= 5);
					if (k == 4)
						seg_len = {b[5:0], 8'h00};
					else if (k == 5)
						seg_len[7:0] = b;
					total = seg_len + 7;
					if (k % 2 == 0) begin
						held   = b;
						held_v = 1'b1;
						if (known && k + 1 == total) begin
							r[0]   = make_beat(held, 1'b1, seg_len, 1'b0);
							n      = 1;
							held_v = 1'b0;
							ph     = PH_TRAIL;
						end
					end else begin
						r[0]   = make_beat(b, 1'b0, 14'd0, 1'b0);
						r[1]   = make_beat(held_v ? held : 8'h00, 1'b0, 14'd0, 1'b0);
						n      = 2;
						held_v = 1'b0;
						if (known && k + 1 == total) begin
							r[1].last          = 1'b1;
							r[1].segment_count = seg_len;
							ph                 = PH_TRAIL;
						end
					end
				end
			end
			rec_idx = rec_idx + 16'd1;
			if (rec_idx >= rec_len) begin
				// record over with the segment still open
				if (ph == PH_SEGMENT) begin
					if (n > 0) begin
						r[n-1].last          = 1'b1;
						r[n-1].segment_count = seg_len;
						r[n-1].truncated     = 1'b1;
					end else begin
						r[0] = make_beat(held_v ? held : 8'h00, 1'b1, seg_len, 1'b1);
						n    = 1;
					end
				end
				held_v  = 1'b0;
				ph      = PH_HUNT;
				hdr_idx = '0;
			end
		end
		for (int i = 0; i < n; i++)
			expected_beats.push_back(r[i]);
	endtask

	task automatic check_beat();
		result_t exp_beat;
		if (expected_beats.size() == 0) begin
			$error("unexpected beat: out_byte=%0h last=%0b segment_count=%0d truncated=%0b",
				out_byte, last, segment_count, truncated);
			fail_count++;
		end else begin
			exp_beat = expected_beats.pop_front();
			if (out_byte !== exp_beat.out_byte) begin
				$error("out_byte: expected %0h, got %0h", exp_beat.out_byte, out_byte);
				fail_count++;
			end
			if (last !== exp_beat.last) begin
				$error("last: expected %0b, got %0b", exp_beat.last, last);
				fail_count++;
			end
			if (segment_count !== exp_beat.segment_count) begin
				$error("segment_count: expected %0d, got %0d",
					exp_beat.segment_count, segment_count);
				fail_count++;
			end
			if (truncated !== exp_beat.truncated) begin
				$error("truncated: expected %0b, got %0b", exp_beat.truncated, truncated);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph      = PH_HUNT;
			hdr_idx = '0;
			rec_len = '0;
			rec_idx = '0;
			seg_off = '0;
			seg_len = '0;
			held    = '0;
			held_v  = 1'b0;
			expected_beats.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (in_valid && !in_stall)
				deframe_byte(data_byte);
			pending <= expected_beats.size();
		end
	end

endmodule

// ----- bench/tb_sync_hunt_record_deframer.sv -----
// Testbench top for the sync-hunt record deframer: clock, reset, byte stimulus, verdict.
`timescale 1ns / 100ps

module tb_sync_hunt_record_deframer;
	import shrd_pkg::*;

	localparam int RAND_ITEMS  = 1600;
	// a correct run finishes far sooner; keep well clear of it
	localparam int CYCLE_LIMIT = 2000000;
	// body cap that never cuts a record short
	localparam int unsigned FULL_BODY = 65535;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic [13:0] segment_count;
	logic        truncated;
	int          fail_count;
	int          pending;

	// idle percentages for the current phase of the run
	int send_idle = 31;
	int recv_stall = 77;
	// framed bytes sent so far (hunt noise is not counted)
	int framed_bytes;
	int cycle_cnt = 0;

	sync_hunt_record_deframer u_top (.*);

	deframe_checker u_checker (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall);

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// One beat on the input channel, with random idle cycles in front.
	// Valid and payload stay put until the beat is taken.
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Partial marker followed by a byte that breaks it; the hunter must retry.
	task automatic send_false_start(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++)
			push_byte(marker_byte(i[3:0]));
		b = 8'($urandom_range(0, 255));
		if (b == marker_byte(n[3:0]))
			b = b ^ 8'h01;
		push_byte(b);
	endtask

	// Full frame: marker, rest of the header with the 32-bit length field,
	// then the record with the offset and count planted where the segment
	// parser looks for them. Record length follows the block's saturate/clamp.
	// At most body_max record bytes are sent.
	task automatic send_record(input logic [31:0] len_field, input logic [15:0] offset,
			input logic [13:0] count, input int unsigned body_max);
		int unsigned rec_bytes, seg_at, sent;
		logic [7:0]  b;
		rec_bytes = (len_field > 32'h0000FFFF) ? 32'h0000FFFF : len_field;
		if (rec_bytes > MAX_RECORD)
			rec_bytes = MAX_RECORD;
		sent   = (rec_bytes < body_max) ? rec_bytes : body_max;
		seg_at = offset + OFFSET_BIAS;
		for (int i = 0; i < MARKER_LEN; i++)
			push_byte(marker_byte(i[3:0]));
		for (int i = MARKER_LEN; i < HEADER_BYTES_DEF - 4; i++)
			push_byte(8'($urandom_range(0, 255)));
		for (int i = 3; i >= 0; i--)
			push_byte(len_field[8*i +: 8]);
		for (int unsigned p = 0; p < sent; p++) begin
			b = 8'($urandom_range(0, 255));
			if (p == 2)
				b = offset[15:8];
			else if (p == 3)
				b = offset[7:0];
			else if (p == seg_at + 4)
				b = {b[7:6], count[13:8]};   // top two bits are don't-care
			else if (p == seg_at + 5)
				b = count[7:0];
			push_byte(b);
		end
		framed_bytes += HEADER_BYTES_DEF + int'(sent);
	endtask

	initial begin
		int          roll;
		int unsigned seg_end, cap;
		logic [15:0] offset;
		logic [13:0] count;
		logic [31:0] len_field;

		// reset held low from the start, released on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed frames ----
		// marker retry: a broken prefix, then a stray N right before the marker
		send_false_start(3);
		push_byte(8'h4E);
		// smallest segment (count 0): seven bytes, odd last byte comes out alone
		send_record(32'd15, 16'd0, 14'd0, FULL_BODY);
		push_byte(8'hFF);
		push_byte(8'h00);
		// zero-length record: one truncated beat straight off the header
		send_record(32'd0, 16'd0, 14'd0, FULL_BODY);
		// even segment length, offset 3, trailing bytes dropped
		send_record(32'd27, 16'd3, 14'd1, FULL_BODY);
		// record ends before the offset is complete
		send_record(32'd3, 16'd0, 14'd0, FULL_BODY);
		// largest offset: segment never starts, no wrap of the start position
		send_record(32'd30, 16'hFFFF, 14'd0, FULL_BODY);
		// cut right after the count high byte: held byte, partial count
		send_record(32'd13, 16'd0, 14'h3FFF, FULL_BODY);
		// cut on an odd segment byte: the pair carries last and truncated
		send_record(32'd16, 16'd0, 14'h3FFF, FULL_BODY);
		// cut on an even segment byte with a full count received
		send_record(32'd17, 16'd0, 14'h2A55, FULL_BODY);
		send_false_start(8);

		// ---- random frames ----
		framed_bytes = 0;
		while (framed_bytes < RAND_ITEMS) begin
			// idling profile by thirds: slow receiver, slow sender, then full rate
			if (framed_bytes < RAND_ITEMS / 3) begin
				send_idle  = 31;
				recv_stall = 77;
			end else if (framed_bytes < 2 * RAND_ITEMS / 3) begin
				send_idle  = 77;
				recv_stall = 31;
			end else begin
				send_idle  = 0;
				recv_stall = 0;
			end

			// line noise and broken markers between frames
			repeat ($urandom_range(0, 3))
				push_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 7) == 0)
				send_false_start($urandom_range(1, 8));

			offset  = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6))
				: 16'($urandom_range(0, 65535));
			count   = ($urandom_range(0, 99) < 85) ? 14'($urandom_range(0, 12))
				: 14'($urandom_range(0, 16383));
			seg_end = offset + OFFSET_BIAS + count + SEG_EXTRA;
			cap     = (seg_end - 1 < 60) ? seg_end - 1 : 60;
			roll    = $urandom_range(0, 99);
			if (roll < 5)
				len_field = 32'd0;
			else if (seg_end <= 60 && roll < 75)
				len_field = seg_end + $urandom_range(0, 4);
			else
				len_field = $urandom_range(1, cap);
			send_record(len_field, offset, count, FULL_BODY);
		end

		// oversized length saturates then clamps; the segment completes early and
		// the rest of the long record is left unsent, so it ends the stream
		send_record(32'h00FF_FFFF, 16'd0, 14'd9, 40);
		in_valid <= 1'b0;

		// drain: everything predicted must come out, then the bench idles before the verdict
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sync_hunt_record_deframer.f -----
rtl/shrd_pkg.sv
rtl/shrd_core.sv
rtl/shrd_resq.sv
rtl/sync_hunt_record_deframer.sv
bench/deframe_checker.sv
bench/tb_sync_hunt_record_deframer.sv
